// ----- design/tbt_pkg.sv -----
// Shared types and constants for the threshold bound table.
`timescale 1ns / 1ps
`default_nettype none

package tbt_pkg;

  localparam int ID_W    = 32;
  localparam int BOUND_W = 32;
  localparam int CNT_W   = 7;
  localparam int POS_W   = 6;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LIT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [ID_W-1:0]    new_id;
    logic [BOUND_W-1:0] new_bound;
    logic [BOUND_W-1:0] lit_weight;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic              id_valid;
    logic              last;
    logic [CNT_W-1:0]  entries_used;
  } res_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_PLAIN,
    RES_DUP,
    RES_SAT
  } res_sel_t;

  typedef struct packed {
    logic              load;
    logic              scan_en;
    logic              lit_proc;
    logic              emit_start;
    logic              sat_scan;
    logic              rem_read;
    logic              rem_write;
    logic              append;
    logic              count_keep;
    res_sel_t          res_sel;
    logic [STAT_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic dv;
    logic dup_hit;
    logic tbl_done;
    logic nsat_zero;
    logic full;
    logic pos_bad;
    logic sat_last;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/threshold_bound_table_core.sv -----
// Top level of the threshold bound table: sequencer plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low. Every request gives
// one or more result beats on result, each marked by a one-cycle result_valid;
// beats of one request come on consecutive cycles and the receiver cannot stall
// them. The table is scanned through a memory with one read port (registered
// output) and one write port, one entry per cycle. An add scans the table and
// stops early when a duplicate bound is found, a true-literal scans the table
// and then streams out each entry that it satisfied, a remove moves the last
// entry into the given position unless that position is out of range, and the
// unused request type gives a single beat with no scan. A new request may
// start in the cycle in which the last beat of the previous one is shown.
module threshold_bound_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tbt_pkg::req_t req,
  output logic          busy,
  output logic          result_valid,
  output tbt_pkg::res_t result
);
  import tbt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  tbt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- design/tbt_datapath.sv -----
// Table storage, scan counters and result register for the threshold bound table.
`timescale 1ns / 1ps
`default_nettype none

module tbt_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  tbt_pkg::req_t req,
  input  tbt_pkg::cmd_t cmd,
  output tbt_pkg::stat_t stat,
  output logic          result_valid,
  output tbt_pkg::res_t result
);
  import tbt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  logic [ID_W-1:0]    id_mem    [TABLE_DEPTH];
  logic [BOUND_W-1:0] bound_mem [TABLE_DEPTH];
  logic [ID_W-1:0]    sat_mem   [TABLE_DEPTH];

  req_t               cur;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   idx1;
  logic [CNT_W-1:0]   keep;
  logic [CNT_W-1:0]   nsat;
  logic [CNT_W-1:0]   last_idx;
  logic               v1;
  logic [ID_W-1:0]    rd_id;
  logic [BOUND_W-1:0] rd_bound;
  logic [ID_W-1:0]    sat_rd;

  logic               tbl_issue;
  logic               sat_issue;
  logic [IDX_W-1:0]   tbl_addr;
  logic               sat_hit;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_W-1:0]    wr_id;
  logic [BOUND_W-1:0] wr_bound;
  logic               sat_wr;
  res_t               res_next;

  assign last_idx  = count - CNT_W'(1);
  assign tbl_issue = (cmd.scan_en && (rd_idx < count)) || cmd.rem_read;
  assign sat_issue = cmd.sat_scan && (rd_idx < nsat);
  assign tbl_addr  = cmd.rem_read ? last_idx[IDX_W-1:0] : rd_idx[IDX_W-1:0];
  assign sat_hit   = rd_bound <= cur.lit_weight;
  assign sat_wr    = cmd.lit_proc && v1 && sat_hit;

  assign stat.dv        = v1;
  assign stat.dup_hit   = v1 && (rd_bound == cur.new_bound);
  assign stat.tbl_done  = !v1 && (rd_idx >= count);
  assign stat.nsat_zero = (nsat == '0);
  assign stat.full      = (count >= DEPTH_C);
  assign stat.pos_bad   = ({1'b0, cur.position} >= count);
  assign stat.sat_last  = ((idx1 + CNT_W'(1)) == nsat);

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = count[IDX_W-1:0];
    wr_id    = cur.new_id;
    wr_bound = cur.new_bound;
    if (cmd.append) begin
      wr_en = 1'b1;
    end else if (cmd.rem_write) begin
      wr_en    = 1'b1;
      wr_addr  = cur.position[IDX_W-1:0];
      wr_id    = rd_id;
      wr_bound = rd_bound;
    end else if (cmd.lit_proc && v1 && !sat_hit) begin
      wr_en    = 1'b1;
      wr_addr  = keep[IDX_W-1:0];
      wr_id    = rd_id;
      wr_bound = rd_bound - cur.lit_weight;
    end
  end

  always_comb begin
    if (cmd.append) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.rem_write) begin
      count_next = last_idx;
    end else if (cmd.count_keep) begin
      count_next = keep;
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    res_next              = '0;
    res_next.status       = cmd.res_status;
    res_next.last         = 1'b1;
    res_next.entries_used = count_next;
    unique case (cmd.res_sel)
      RES_NONE, RES_PLAIN: begin
      end
      RES_DUP: begin
        res_next.out_id   = rd_id;
        res_next.id_valid = 1'b1;
      end
      RES_SAT: begin
        res_next.out_id   = sat_rd;
        res_next.id_valid = 1'b1;
        res_next.last     = stat.sat_last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      v1           <= 1'b0;
      rd_idx       <= '0;
      keep         <= '0;
      nsat         <= '0;
      result_valid <= 1'b0;
    end else begin
      count        <= count_next;
      result_valid <= (cmd.res_sel != RES_NONE);
      if (cmd.load || cmd.emit_start) begin
        v1     <= 1'b0;
        rd_idx <= '0;
      end else begin
        v1 <= tbl_issue || sat_issue;
        if ((tbl_issue && !cmd.rem_read) || sat_issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
      end
      if (cmd.load) begin
        keep <= '0;
        nsat <= '0;
      end else if (cmd.lit_proc && v1) begin
        if (sat_hit) begin
          nsat <= nsat + CNT_W'(1);
        end else begin
          keep <= keep + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    idx1   <= rd_idx;
    result <= res_next;
    if (tbl_issue) begin
      rd_id    <= id_mem[tbl_addr];
      rd_bound <= bound_mem[tbl_addr];
    end
    if (sat_issue) begin
      sat_rd <= sat_mem[rd_idx[IDX_W-1:0]];
    end
    if (wr_en) begin
      id_mem[wr_addr]    <= wr_id;
      bound_mem[wr_addr] <= wr_bound;
    end
    if (sat_wr) begin
      sat_mem[nsat[IDX_W-1:0]] <= rd_id;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above table depth");

  a_id_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.id_valid |-> result.out_id == '0)
    else $error("out_id not cleared on a beat without id");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    cmd.lit_proc && v1 |-> keep <= idx1)
    else $error("compaction write passed the read pointer");

endmodule

`default_nettype wire

// ----- design/tbt_ctrl.sv -----
// Request sequencer for the threshold bound table.
`timescale 1ns / 1ps
`default_nettype none

module tbt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tbt_pkg::REQ_W-1:0]   req_type,
  input  tbt_pkg::stat_t              stat,
  output logic                        busy,
  output tbt_pkg::cmd_t               cmd
);
  import tbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_LIT_SCAN,
    S_LIT_EMIT,
    S_REM_READ,
    S_REM_WRITE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.res_sel    = RES_NONE;
    cmd.res_status = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (req_type)
            REQ_ADD:    state_next = S_ADD_SCAN;
            REQ_LIT:    state_next = S_LIT_SCAN;
            REQ_REMOVE: state_next = S_REM_READ;
            REQ_NOP:    cmd.res_sel = RES_PLAIN;
          endcase
        end
      end
      S_ADD_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.dup_hit) begin
          cmd.res_sel    = RES_DUP;
          cmd.res_status = ST_DUP;
          state_next     = S_IDLE;
        end else if (stat.tbl_done) begin
          cmd.res_sel = RES_PLAIN;
          state_next  = S_IDLE;
          if (stat.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      S_LIT_SCAN: begin
        cmd.scan_en  = 1'b1;
        cmd.lit_proc = 1'b1;
        if (stat.tbl_done) begin
          cmd.count_keep = 1'b1;
          cmd.emit_start = 1'b1;
          if (stat.nsat_zero) begin
            cmd.res_sel = RES_PLAIN;
            state_next  = S_IDLE;
          end else begin
            state_next = S_LIT_EMIT;
          end
        end
      end
      S_LIT_EMIT: begin
        cmd.sat_scan = 1'b1;
        if (stat.dv) begin
          cmd.res_sel = RES_SAT;
          if (stat.sat_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_REM_READ: begin
        if (stat.pos_bad) begin
          cmd.res_sel    = RES_PLAIN;
          cmd.res_status = ST_RANGE;
          state_next     = S_IDLE;
        end else begin
          cmd.rem_read = 1'b1;
          state_next   = S_REM_WRITE;
        end
      end
      S_REM_WRITE: begin
        cmd.rem_write = 1'b1;
        cmd.res_sel   = RES_PLAIN;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy out of step with sequencer state");

  a_no_append_full: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !stat.full)
    else $error("append issued to a full table");

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_LIT_EMIT && stat.dv && stat.sat_last |=> state == S_IDLE)
    else $error("emit phase did not end after the last beat");

endmodule

`default_nettype wire
